[hw/rtl/lapc_pkg.sv]
package lapc_pkg;

    localparam int AMP_W     = 32;
    localparam int MANT_W    = 8;
    localparam int EXPC_W    = 7;
    localparam int EXPO_W    = 6;
    localparam int TH_FRAC   = 24;
    localparam int SCALED_W  = 56;
    localparam int GAIN_W    = 34;
    localparam int GAIN_LO_W = 17;
    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam int PP_W      = AMP_W + GAIN_LO_W;
    localparam int PROD_W    = AMP_W + GAIN_W;
    localparam int GAIN_ENTRIES = 48;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [SCALED_W-1:0] C_EVEN = SCALED_W'(64'd10277600);
    localparam logic [SCALED_W-1:0] C_ODD  = SCALED_W'(64'd14534721);

    localparam logic [PROD_W-1:0]  MANT_BIAS = PROD_W'(615);
    localparam logic [PROD_W-1:0]  MANT_TOP  = PROD_W'(615 + 255);
    localparam logic [MANT_W-1:0]  MANT_MAX  = 8'd255;
    localparam logic [EXPC_W-1:0]  NEG_BASE  = 7'd96;

    localparam logic [63:0] ODD_NUM   = 64'd712 << 25;
    localparam logic [63:0] EVEN_NUM  = 64'd712 << 53;
    localparam logic [63:0] SQRT2_Q28 = 64'd379625062;
    localparam logic [63:0] ONE_Q28   = 64'd1 << 28;

    // gain per exponent step, 24 fraction bits
    localparam logic [63:0] GAIN_ROM [GAIN_ENTRIES] = '{
        64'd712 << 24,
        ODD_NUM  / ((64'd1 << 1) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 1) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 2) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 2) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 3) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 3) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 4) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 4) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 5) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 5) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 6) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 6) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 7) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 7) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 8) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 8) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 9) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 9) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 10) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 10) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 11) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 11) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 12) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 12) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 13) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 13) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 14) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 14) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 15) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 15) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 16) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 16) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 17) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 17) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 18) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 18) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 19) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 19) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 20) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 20) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 21) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 21) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 22) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 22) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 23) + 64'd1),
        EVEN_NUM / ((SQRT2_Q28 << 23) + ONE_Q28),
        ODD_NUM  / ((64'd1 << 24) + 64'd1)
    };

    typedef struct packed {
        logic [AMP_W-1:0]  mag;
        logic              neg;
        logic              tiny;
        logic [EXPO_W-1:0] expo;
    } t_cls;

    typedef struct packed {
        logic [MANT_W-1:0] mantissa;
        logic [EXPC_W-1:0] exponent;
    } t_res;

    // step threshold, 24 fraction bits
    function automatic logic [SCALED_W-1:0] lapc_th(input int unsigned k);
        logic [SCALED_W-1:0] th;
        if (k[0]) begin
            th = C_ODD << ((k - 1) >> 1);
        end else begin
            th = C_EVEN << (k >> 1);
        end
        return th;
    endfunction

endpackage

[hw/rtl/lapc_queue.sv]
module lapc_queue import lapc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

[hw/rtl/lapc_front.sv]
module lapc_front import lapc_pkg::*; #(
    parameter int EXP_STEPS = 47,
    parameter int FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic signed [AMP_W-1:0] i_amplitude,
    output logic                    o_valid,
    output t_cls                    o_cls
);

    localparam int SHIFT = TH_FRAC - FRAC_BITS;
    localparam logic [AMP_W-1:0] HALF = AMP_W'(64'd1 << (FRAC_BITS - 1));

    logic                  r_valid;
    logic [AMP_W-1:0]      r_mag;
    logic                  r_neg;
    logic                  r_tiny;
    logic [EXP_STEPS-1:0]  r_therm;

    logic [AMP_W-1:0]      n_mag;
    logic [SCALED_W-1:0]   scaled;
    logic [EXP_STEPS-1:0]  n_therm;
    logic [EXPO_W-1:0]     expo;

    always_comb begin
        n_mag  = i_amplitude[AMP_W-1] ? (~i_amplitude + AMP_W'(1)) : i_amplitude;
        scaled = SCALED_W'(n_mag) << SHIFT;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            n_therm[k-1] = scaled >= lapc_th(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_mag   <= n_mag;
            r_neg   <= i_amplitude[AMP_W-1];
            r_tiny  <= n_mag < HALF;
            r_therm <= n_therm;
        end
    end

    // thresholds rise with k, so the highest step passed is the exponent
    always_comb begin
        expo = '0;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            if (r_therm[k-1]) begin
                expo = EXPO_W'(k);
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_cls.mag  = r_mag;
    assign o_cls.neg  = r_neg;
    assign o_cls.tiny = r_tiny;
    assign o_cls.expo = expo;

endmodule

[hw/rtl/lapc_back.sv]
module lapc_back import lapc_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cls       i_cls,
    output logic       o_valid,
    output t_res       o_res,
    output logic [1:0] o_inflight
);

    localparam int MANT_SHIFT = TH_FRAC + FRAC_BITS;

    // stage 0: gain lookup
    logic              r_s0_valid;
    logic [AMP_W-1:0]  r_s0_mag;
    logic [GAIN_W-1:0] r_s0_gain;
    logic              r_s0_neg;
    logic              r_s0_tiny;
    logic [EXPO_W-1:0] r_s0_expo;

    // stage 1: partial products
    logic              r_s1_valid;
    logic [PP_W-1:0]   r_s1_lo;
    logic [PP_W-1:0]   r_s1_hi;
    logic              r_s1_neg;
    logic              r_s1_tiny;
    logic [EXPO_W-1:0] r_s1_expo;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] mraw;
    logic [MANT_W-1:0] mant;
    logic [EXPC_W-1:0] expc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mag  <= i_cls.mag;
        r_s0_gain <= GAIN_ROM[i_cls.expo][GAIN_W-1:0];
        r_s0_neg  <= i_cls.neg;
        r_s0_tiny <= i_cls.tiny;
        r_s0_expo <= i_cls.expo;

        r_s1_lo   <= PP_W'(r_s0_mag) * PP_W'(r_s0_gain[GAIN_LO_W-1:0]);
        r_s1_hi   <= PP_W'(r_s0_mag) * PP_W'(r_s0_gain[GAIN_W-1:GAIN_LO_W]);
        r_s1_neg  <= r_s0_neg;
        r_s1_tiny <= r_s0_tiny;
        r_s1_expo <= r_s0_expo;
    end

    always_comb begin
        prod = PROD_W'(r_s1_lo) + (PROD_W'(r_s1_hi) << GAIN_LO_W);
        mraw = prod >> MANT_SHIFT;
        if (r_s1_tiny || mraw <= MANT_BIAS) begin
            mant = '0;
        end else if (mraw > MANT_TOP) begin
            mant = MANT_MAX;
        end else begin
            mant = MANT_W'(mraw - MANT_BIAS);
        end
        if (r_s1_tiny) begin
            expc = '0;
        end else if (r_s1_neg && r_s1_expo != '0) begin
            expc = NEG_BASE - EXPC_W'(r_s1_expo);
        end else begin
            expc = EXPC_W'(r_s1_expo);
        end
    end

    assign o_valid        = r_s1_valid;
    assign o_res.mantissa = mant;
    assign o_res.exponent = expc;
    assign o_inflight     = 2'(r_s0_valid) + 2'(r_s1_valid);

endmodule

[hw/rtl/log_amplitude_byte_pair_compressor_core.sv]
// channel  | transfer when        | payload
// ---------+----------------------+----------------------------------
// input    | i_push && !o_full    | i_amplitude (32 b, signed Q.FRAC_BITS)
// result   | i_pop && !o_empty    | o_mantissa (8 b), o_exponent (7 b)
//
// One amplitude a cycle sustained while results are popped; after its transfer in, a result passes
// the input compare stage, queue write, gain lookup stage, product stage and result queue.
// The two 32x17 partial products of the gain multiply set the back-end stage depth.
// Synchronous reset empties both queues and the pipeline valids.
// A stalled result side fills the result queue, then the middle queue, then raises o_full.
module log_amplitude_byte_pair_compressor_core import lapc_pkg::*; #(
    parameter int EXP_STEPS = 47,
    parameter int FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic signed [AMP_W-1:0] i_amplitude,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [MANT_W-1:0]       o_mantissa,
    output logic [EXPC_W-1:0]       o_exponent
);

    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic                 take;
    logic                 fe_valid;
    t_cls                 fe_cls;
    t_cls                 mid_head;
    logic [MID_CNT_W-1:0] mid_count;
    logic                 mid_pop;
    logic                 be_valid;
    t_res                 be_res;
    logic [1:0]           be_inflight;
    t_res                 out_head;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_pop;

    // the front stage always drains into the middle queue next cycle
    assign o_full = (MID_CNT_W'(32'(mid_count) + 32'(fe_valid))) >= MID_CNT_W'(MID_DEPTH);
    assign take   = i_push && !o_full;

    lapc_front #(
        .EXP_STEPS (EXP_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_amplitude (i_amplitude),
        .o_valid     (fe_valid),
        .o_cls       (fe_cls)
    );

    lapc_queue #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_data  (fe_cls),
        .i_pop   (mid_pop),
        .o_data  (mid_head),
        .o_count (mid_count)
    );

    // issue only when the result queue has room for everything in flight
    assign mid_pop = (mid_count != '0) &&
        ((32'(out_count) + 32'(be_inflight)) < OUT_DEPTH);

    lapc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (mid_pop),
        .i_cls      (mid_head),
        .o_valid    (be_valid),
        .o_res      (be_res),
        .o_inflight (be_inflight)
    );

    lapc_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_valid),
        .i_data  (be_res),
        .i_pop   (out_pop),
        .o_data  (out_head),
        .o_count (out_count)
    );

    assign o_empty    = out_count == '0;
    assign out_pop    = i_pop && !o_empty;
    assign o_mantissa = out_head.mantissa;
    assign o_exponent = out_head.exponent;

endmodule

[tb/sv/lapc_result_checker.sv]
module lapc_result_checker import lapc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [AMP_W-1:0]  i_amplitude,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [MANT_W-1:0] i_mantissa,
    input  logic [EXPC_W-1:0] i_exponent,
    output int                o_errors,
    output int                o_waiting,
    output int                o_checked,
    output int                o_codes_seen
);

    localparam int STEPS      = 47;
    localparam int FRAC       = 8;
    localparam int EDGE_FRAC  = 24;
    localparam logic [63:0] EDGE_EVEN = 64'd10277600;
    localparam logic [63:0] EDGE_ODD  = 64'd14534721;
    localparam logic [63:0] ROOT2_Q28 = 64'd379625062;
    localparam logic [63:0] GAIN_SCALE = 64'd712;
    localparam logic [95:0] BIAS      = 96'd615;
    localparam logic [95:0] SPAN      = 96'd255;

    typedef struct {
        logic [AMP_W-1:0] amp;
        t_res             res;
    } t_amp_code;

    t_amp_code  expected_codes[$];
    logic [127:0] codes_hit = '0;
    int errors_n  = 0;
    int checked_n = 0;

    function automatic logic [63:0] step_edge(input int unsigned k);
        if (k[0]) begin
            return EDGE_ODD << ((k - 1) >> 1);
        end
        return EDGE_EVEN << (k >> 1);
    endfunction

    function automatic logic [63:0] step_gain(input int unsigned e);
        int unsigned half;
        half = e >> 1;
        if (e == 0) begin
            return GAIN_SCALE << 24;
        end
        if (e[0]) begin
            return (GAIN_SCALE << 25) / ((64'd1 << (half + 1)) + 64'd1);
        end
        return (GAIN_SCALE << 53) / ((ROOT2_Q28 << half) + (64'd1 << 28));
    endfunction

    function automatic t_res compress_amplitude(input logic [AMP_W-1:0] amp);
        logic         neg;
        logic [32:0]  mag;
        logic [63:0]  scaled;
        logic [127:0] prod;
        logic [95:0]  raw;
        int unsigned  e;
        t_res         r;
        r   = '0;
        neg = amp[AMP_W-1];
        mag = neg ? ({1'b0, ~amp} + 33'd1) : {1'b0, amp};
        if (mag < (33'd1 << (FRAC - 1))) begin
            return r;
        end
        scaled = 64'(mag) << (EDGE_FRAC - FRAC);
        e = 0;
        for (int k = 1; k <= STEPS; k++) begin
            if (scaled >= step_edge(k)) begin
                e = k;
            end
        end
        prod = 128'(mag) * 128'(step_gain(e));
        // product past 64 bits saturates the mantissa
        if (prod[127:64] != '0) begin
            r.mantissa = MANT_MAX;
        end else begin
            raw = 96'(prod >> (EDGE_FRAC + FRAC));
            if (raw <= BIAS) begin
                r.mantissa = '0;
            end else if (raw - BIAS > SPAN) begin
                r.mantissa = MANT_MAX;
            end else begin
                r.mantissa = MANT_W'(raw - BIAS);
            end
        end
        if (neg && e != 0) begin
            r.exponent = NEG_BASE - EXPC_W'(e);
        end else begin
            r.exponent = EXPC_W'(e);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_amp_code item;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (expected_codes.size() == 0) begin
                    $error("result transfer with nothing expected: mantissa %0d exponent %0d",
                           i_mantissa, i_exponent);
                    errors_n++;
                end else begin
                    item = expected_codes.pop_front();
                    if (i_mantissa !== item.res.mantissa) begin
                        $error("mantissa (amplitude %h): expected %0d, actual %0d",
                               item.amp, item.res.mantissa, i_mantissa);
                        errors_n++;
                    end
                    if (i_exponent !== item.res.exponent) begin
                        $error("exponent (amplitude %h): expected %0d, actual %0d",
                               item.amp, item.res.exponent, i_exponent);
                        errors_n++;
                    end
                    checked_n++;
                end
            end
            if (i_push && !i_full) begin
                item.amp = i_amplitude;
                item.res = compress_amplitude(i_amplitude);
                expected_codes.push_back(item);
                codes_hit[item.res.exponent] = 1'b1;
            end
        end
        o_errors     <= errors_n;
        o_checked    <= checked_n;
        o_waiting    <= expected_codes.size();
        o_codes_seen <= $countones(codes_hit);
    end

endmodule

[tb/sv/log_amplitude_byte_pair_compressor_core_test.sv]
module log_amplitude_byte_pair_compressor_core_test;
    import lapc_pkg::*;

    localparam int N_RANDOM     = 1730;
    localparam int CALM_TAIL    = 250;
    localparam int DRAIN_CYCLES = 24;
    localparam int TIME_LIMIT   = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_push;
    logic              i_pop;
    logic [AMP_W-1:0]  i_amplitude;
    logic              o_full;
    logic              o_empty;
    logic [MANT_W-1:0] o_mantissa;
    logic [EXPC_W-1:0] o_exponent;

    int errors;
    int waiting;
    int checked;
    int codes_seen;
    int sent;
    bit calm;

    log_amplitude_byte_pair_compressor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_amplitude(i_amplitude),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_mantissa (o_mantissa),
        .o_exponent (o_exponent)
    );

    lapc_result_checker result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_full      (o_full),
        .i_amplitude (i_amplitude),
        .i_empty     (o_empty),
        .i_pop       (i_pop),
        .i_mantissa  (o_mantissa),
        .i_exponent  (o_exponent),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_checked   (checked),
        .o_codes_seen(codes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIME_LIMIT);
        $display("log_amplitude_byte_pair_compressor_core_test: done, errors");
        $finish;
    end

    // smallest magnitude (Q.8) that reaches exponent step k
    function automatic logic [31:0] step_start(input int unsigned k);
        logic [63:0] edge_q24;
        if (k[0]) begin
            edge_q24 = 64'd14534721 << ((k - 1) >> 1);
        end else begin
            edge_q24 = 64'd10277600 << (k >> 1);
        end
        return 32'((edge_q24 + 64'hFFFF) >> 16);
    endfunction

    function automatic logic [31:0] pick_amplitude();
        logic [31:0] v;
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 35) begin
            v = $urandom >> $urandom_range(0, 31);
        end else if (mode < 60) begin
            v = step_start($urandom_range(1, 47)) + $urandom_range(0, 2) - 1;
        end else if (mode < 80) begin
            return $urandom;
        end else if (mode < 90) begin
            v = $urandom_range(0, 300);
        end else begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h8000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if ($urandom_range(0, 1)) begin
            v = -v;
        end
        return v;
    endfunction

    // hold push until the transfer happens
    task automatic send_amplitude(input logic [31:0] v);
        i_push      <= 1'b1;
        i_amplitude <= v;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    initial begin
        i_pop <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_pop <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] directed[$];
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_amplitude <= '0;
        sent = 0;
        calm = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, the half boundary, the bottom step, extremes, first and top steps
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd127, 32'd128, -32'd128, -32'd127,
                     32'd129, 32'd221, 32'd222, -32'd222, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'h4000_0000, -32'h4000_0000, 32'h0001_0000,
                     step_start(1), step_start(2) - 1, step_start(47), step_start(47) - 1,
                     -step_start(47), 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (directed[n]) begin
            send_amplitude(directed[n]);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - CALM_TAIL) begin
                calm <= 1'b1;
            end
            send_amplitude(pick_amplitude());
        end
        i_push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d amplitudes sent (signs, step edges, extremes), %0d results compared,",
                 sent, checked);
        $display("%0d distinct exponent codes expected", codes_seen);
        if (errors == 0) begin
            $display("log_amplitude_byte_pair_compressor_core_test: done, clean");
        end else begin
            $display("log_amplitude_byte_pair_compressor_core_test: done, errors");
        end
        $finish;
    end

endmodule
